// ----- rtl/p2pbgra_pkg.sv -----
// Shared types, register indexes and constants for the BGRA pixel converter.
package p2pbgra_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam int BYTE_W  = 8;
  localparam int COLOR_W = 24;
  localparam int PIXEL_W = 32;
  localparam int POS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2;

  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hff;

  // alpha_flags bit positions
  localparam int FLAG_ALPHA_SRC_BIT = 0;
  localparam int FLAG_PREMUL_BIT    = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_POS      = 3'd0,
    REG_GREEN_POS    = 3'd1,
    REG_BLUE_POS     = 3'd2,
    REG_ALPHA_POS    = 3'd3,
    REG_ALPHA_FLAGS  = 3'd4,
    REG_PALETTE_MODE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0] red_pos;
    logic [POS_W-1:0] green_pos;
    logic [POS_W-1:0] blue_pos;
    logic [POS_W-1:0] alpha_pos;
    logic [1:0]       alpha_flags;
    logic             palette_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    red_pos:      2'd0,
    green_pos:    2'd1,
    blue_pos:     2'd2,
    alpha_pos:    2'd3,
    alpha_flags:  2'd0,
    palette_mode: 1'b0
  };

endpackage

// ----- rtl/pixel_to_premultiplied_bgra.sv -----
// Top level of the source-pixel to premultiplied BGRA converter.
//
// Input channel (in_valid / in_stall) carries one request per pixel or
// palette write: in_action 0 converts in_pixel_bytes, in_action 1 stores
// in_entry_color at in_entry_index and yields no result.
// Result channel (out_valid / out_stall) returns one BGRA pixel per
// conversion request, in request order.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
// sets byte positions, alpha flags and palette mode; cfg_ready is always
// high. Write it only while no request is in flight.
// Pipeline: an accepted request lands in the input register with its palette
// read issued at the same edge; pick and premultiply then load the result
// register when it is empty or being taken, and the result leaves from there.
// Throughput: one request per cycle sustained while the result is not stalled.
// Reset: rst_n clears pipeline valids and loads R=0, G=1, B=2, A=3, opaque
// alpha, direct mode. Palette contents are undefined until written; a lookup
// at or above the palette size yields black with opaque alpha.
// Stall: a stalled result holds steady; the input register keeps taking
// requests until it is full behind the held result, then in_stall rises.
module pixel_to_premultiplied_bgra #(
  parameter int PALETTE_ENTRIES = p2pbgra_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic [p2pbgra_pkg::PIXEL_W-1:0]      in_pixel_bytes,
  input  logic [p2pbgra_pkg::BYTE_W-1:0]       in_entry_index,
  input  logic [p2pbgra_pkg::COLOR_W-1:0]      in_entry_color,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [p2pbgra_pkg::BYTE_W-1:0]       out_blue,
  output logic [p2pbgra_pkg::BYTE_W-1:0]       out_green,
  output logic [p2pbgra_pkg::BYTE_W-1:0]       out_red,
  output logic [p2pbgra_pkg::BYTE_W-1:0]       out_alpha,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [p2pbgra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [p2pbgra_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import p2pbgra_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [BYTE_W:0] ENTRIES_LIM = (BYTE_W+1)'(PALETTE_ENTRIES);

  cfg_t cfg;

  // handshake
  logic accept;
  logic accept_conv;
  logic accept_wr;
  logic advance;
  logic wr_in_range;
  logic rd_in_range;

  // stage 1: registered pixel, palette read in flight
  logic               s1_valid_r, s1_valid_nxt;
  logic [PIXEL_W-1:0] s1_pixel_r;
  logic               s1_hit_r;
  logic [COLOR_W-1:0] pal_color;

  // stage 2: result register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] blue_r, green_r, red_r, alpha_r;
  logic [BYTE_W-1:0] conv_blue, conv_green, conv_red, conv_alpha;

  assign cfg_ready = 1'b1;

  p2pbgra_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the result register when it is empty or being taken; stall the
  // input only when stage 1 is full and cannot move.
  assign advance     = !out_valid_r || !out_stall;
  assign in_stall    = s1_valid_r && !advance;
  assign accept      = in_valid && !in_stall;
  assign accept_conv = accept && !in_action;
  assign accept_wr   = accept && in_action;

  // drop palette writes past the configured palette size; lookups past it miss
  assign wr_in_range = {1'b0, in_entry_index} < ENTRIES_LIM;
  assign rd_in_range = {1'b0, in_pixel_bytes[BYTE_W-1:0]} < ENTRIES_LIM;

  p2pbgra_palette #(
    .ENTRIES (PALETTE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_palette (
    .clk     (clk),
    .wr_en   (accept_wr && wr_in_range),
    .wr_addr (in_entry_index[IDX_W-1:0]),
    .wr_data (in_entry_color),
    .rd_en   (accept_conv),
    .rd_addr (in_pixel_bytes[IDX_W-1:0]),
    .rd_data (pal_color)
  );

  always_comb begin
    if (accept_conv) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_conv) begin
      s1_pixel_r <= in_pixel_bytes;
      s1_hit_r   <= rd_in_range;
    end
  end

  p2pbgra_convert u_convert (
    .cfg       (cfg),
    .pixel     (s1_pixel_r),
    .pal_color (pal_color),
    .pal_hit   (s1_hit_r),
    .blue      (conv_blue),
    .green     (conv_green),
    .red       (conv_red),
    .alpha     (conv_alpha)
  );

  // hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      blue_r  <= conv_blue;
      green_r <= conv_green;
      red_r   <= conv_red;
      alpha_r <= conv_alpha;
    end
  end

  assign out_valid = out_valid_r;
  assign out_blue  = blue_r;
  assign out_green = green_r;
  assign out_red   = red_r;
  assign out_alpha = alpha_r;

endmodule

// ----- rtl/p2pbgra_cfg.sv -----
// Configuration register file of the BGRA pixel converter.
module p2pbgra_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [p2pbgra_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [p2pbgra_pkg::CFG_DATA_W-1:0]   wr_data,
  output p2pbgra_pkg::cfg_t                    cfg
);
  import p2pbgra_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_RED_POS:      cfg_nxt.red_pos      = wr_data;
        REG_GREEN_POS:    cfg_nxt.green_pos    = wr_data;
        REG_BLUE_POS:     cfg_nxt.blue_pos     = wr_data;
        REG_ALPHA_POS:    cfg_nxt.alpha_pos    = wr_data;
        REG_ALPHA_FLAGS:  cfg_nxt.alpha_flags  = wr_data;
        REG_PALETTE_MODE: cfg_nxt.palette_mode = wr_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/p2pbgra_palette.sv -----
// Palette memory: one write port, one registered read port.
module p2pbgra_palette #(
  parameter int ENTRIES = p2pbgra_pkg::PALETTE_ENTRIES_DEF,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [IDX_W-1:0]                   wr_addr,
  input  logic [p2pbgra_pkg::COLOR_W-1:0]    wr_data,
  input  logic                               rd_en,
  input  logic [IDX_W-1:0]                   rd_addr,
  output logic [p2pbgra_pkg::COLOR_W-1:0]    rd_data
);
  import p2pbgra_pkg::*;

  logic [COLOR_W-1:0] mem [ENTRIES];
  logic [COLOR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data while the stage above is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/p2pbgra_convert.sv -----
// Channel pick, alpha select and premultiply for one registered pixel.
module p2pbgra_convert (
  input  p2pbgra_pkg::cfg_t                    cfg,
  input  logic [p2pbgra_pkg::PIXEL_W-1:0]      pixel,
  input  logic [p2pbgra_pkg::COLOR_W-1:0]      pal_color,
  input  logic                                 pal_hit,
  output logic [p2pbgra_pkg::BYTE_W-1:0]       blue,
  output logic [p2pbgra_pkg::BYTE_W-1:0]       green,
  output logic [p2pbgra_pkg::BYTE_W-1:0]       red,
  output logic [p2pbgra_pkg::BYTE_W-1:0]       alpha
);
  import p2pbgra_pkg::*;

  function automatic logic [BYTE_W-1:0] pick(input logic [PIXEL_W-1:0] word,
                                             input logic [POS_W-1:0]   pos);
    return word[pos*BYTE_W +: BYTE_W];
  endfunction

  // c*a/255 for 8-bit operands: exact as (p + (p >> 8) + 1) >> 8
  function automatic logic [BYTE_W-1:0] premul(input logic [BYTE_W-1:0] c,
                                               input logic [BYTE_W-1:0] a);
    logic [2*BYTE_W-1:0] prod;
    logic [2*BYTE_W:0]   sum;
    prod = {{BYTE_W{1'b0}}, c} * {{BYTE_W{1'b0}}, a};
    sum  = {1'b0, prod} + {{(BYTE_W+1){1'b0}}, prod[2*BYTE_W-1:BYTE_W]} +
           (2*BYTE_W+1)'(1);
    return sum[2*BYTE_W-1:BYTE_W];
  endfunction

  logic [BYTE_W-1:0] r_pick, g_pick, b_pick, a_pick;

  always_comb begin
    r_pick = pick(pixel, cfg.red_pos);
    g_pick = pick(pixel, cfg.green_pos);
    b_pick = pick(pixel, cfg.blue_pos);
    a_pick = cfg.alpha_flags[FLAG_ALPHA_SRC_BIT] ? pick(pixel, cfg.alpha_pos)
                                                  : ALPHA_OPAQUE;
    if (cfg.palette_mode) begin
      red   = pal_hit ? pal_color[BYTE_W-1:0]          : '0;
      green = pal_hit ? pal_color[2*BYTE_W-1:BYTE_W]   : '0;
      blue  = pal_hit ? pal_color[3*BYTE_W-1:2*BYTE_W] : '0;
      alpha = ALPHA_OPAQUE;
    end else if (cfg.alpha_flags[FLAG_PREMUL_BIT]) begin
      red   = premul(r_pick, a_pick);
      green = premul(g_pick, a_pick);
      blue  = premul(b_pick, a_pick);
      alpha = a_pick;
    end else begin
      red   = r_pick;
      green = g_pick;
      blue  = b_pick;
      alpha = a_pick;
    end
  end

endmodule

// ----- rtl/p2pbgra_checker.sv -----
// Port-level checker for the BGRA pixel converter, bound to the top level.
module p2pbgra_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [p2pbgra_pkg::BYTE_W-1:0]       out_blue,
  input logic [p2pbgra_pkg::BYTE_W-1:0]       out_green,
  input logic [p2pbgra_pkg::BYTE_W-1:0]       out_red,
  input logic [p2pbgra_pkg::BYTE_W-1:0]       out_alpha
);
  import p2pbgra_pkg::*;

  // no result survives a reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with the result register empty, the input side must take a request
  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // an empty result register fills only from a request that was accepted earlier
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !$past(in_valid && !in_stall)) |=> !out_valid)
    else $error("result appeared without a request in flight");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_blue) && $stable(out_green) &&
                               $stable(out_red) && $stable(out_alpha))
    else $error("stalled result changed");

endmodule

bind pixel_to_premultiplied_bgra p2pbgra_checker u_p2pbgra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_blue  (out_blue),
  .out_green (out_green),
  .out_red   (out_red),
  .out_alpha (out_alpha)
);

// ----- sim/pixel_to_premultiplied_bgra_tb.sv -----
// Self-checking testbench for the pixel to premultiplied BGRA converter.
`timescale 1ns / 100ps

module pixel_to_premultiplied_bgra_tb;
  import p2pbgra_pkg::*;

  localparam int PAL_SIZE = PALETTE_ENTRIES_DEF;
  // A result passes the input and result registers after its request; palette
  // writes give none, so let the pipe drain before touching the
  // registers.
  localparam int DRAIN_CYCLES = 4;
  // Cycles without any handshake before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;

  localparam logic ACT_CONVERT   = 1'b0;
  localparam logic ACT_PAL_WRITE = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] alpha;
  } bgra_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_action = ACT_CONVERT;
  logic [PIXEL_W-1:0]    in_pixel_bytes = '0;
  logic [BYTE_W-1:0]     in_entry_index = '0;
  logic [COLOR_W-1:0]    in_entry_color = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_blue;
  logic [BYTE_W-1:0]     out_green;
  logic [BYTE_W-1:0]     out_red;
  logic [BYTE_W-1:0]     out_alpha;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: register copy and palette contents as the block sees them.
  cfg_t                  model_cfg = CFG_RESET;
  logic [COLOR_W-1:0]    pal_model [PAL_SIZE];
  bit                    pal_written [PAL_SIZE];
  int                    pal_filled [$];

  bgra_t                 expected_pixels [$];
  int                    mismatches = 0;

  // Idling controls for the sender, the receiver and the tests, and the watchdog count.
  bit                    quiet_mode = 1'b0;
  int                    hold_left = 0;
  int                    stall_left = 0;
  int                    idle_cycles = 0;

  pixel_to_premultiplied_bgra dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_pixel_bytes (in_pixel_bytes),
    .in_entry_index (in_entry_index),
    .in_entry_color (in_entry_color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_alpha      (out_alpha),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [BYTE_W-1:0] byte_at(logic [PIXEL_W-1:0] src,
                                                logic [POS_W-1:0] pos);
    return src[8*pos +: 8];
  endfunction

  // Premultiply truncates: color * alpha / 255.
  function automatic logic [BYTE_W-1:0] scale_by_alpha(logic [BYTE_W-1:0] c,
                                                       logic [BYTE_W-1:0] a);
    int prod;
    prod = (int'(c) * int'(a)) / 255;
    return prod[BYTE_W-1:0];
  endfunction

  function automatic bgra_t predict_pixel(logic [PIXEL_W-1:0] src);
    bgra_t              p;
    logic [COLOR_W-1:0] entry;
    if (model_cfg.palette_mode) begin
      // Byte positions and alpha flags play no part in a palette lookup.
      entry = '0;
      if (int'(src[7:0]) < PAL_SIZE) entry = pal_model[src[7:0]];
      p.red   = entry[7:0];
      p.green = entry[15:8];
      p.blue  = entry[23:16];
      p.alpha = ALPHA_OPAQUE;
    end else begin
      p.red   = byte_at(src, model_cfg.red_pos);
      p.green = byte_at(src, model_cfg.green_pos);
      p.blue  = byte_at(src, model_cfg.blue_pos);
      p.alpha = model_cfg.alpha_flags[FLAG_ALPHA_SRC_BIT] ?
                byte_at(src, model_cfg.alpha_pos) : ALPHA_OPAQUE;
      // Without source alpha the factor is 255, so colors pass unchanged.
      if (model_cfg.alpha_flags[FLAG_PREMUL_BIT]) begin
        p.red   = scale_by_alpha(p.red, p.alpha);
        p.green = scale_by_alpha(p.green, p.alpha);
        p.blue  = scale_by_alpha(p.blue, p.alpha);
      end
    end
    return p;
  endfunction

  function automatic cfg_t make_cfg(int r, int g, int b, int a, int f, int m);
    cfg_t c;
    c.red_pos      = r[POS_W-1:0];
    c.green_pos    = g[POS_W-1:0];
    c.blue_pos     = b[POS_W-1:0];
    c.alpha_pos    = a[POS_W-1:0];
    c.alpha_flags  = f[1:0];
    c.palette_mode = m[0];
    return c;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until accepted. Valid stays high on return
  // so back-to-back calls stream without a bubble unless a random pause is drawn.
  task automatic send_request(logic act, logic [PIXEL_W-1:0] px,
                              logic [BYTE_W-1:0] idx, logic [COLOR_W-1:0] col);
    int gap;
    gap = 0;
    if (!quiet_mode && $urandom_range(0, 99) < 35) gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_pixel_bytes <= px;
    in_entry_index <= idx;
    in_entry_color <= col;
    do @(posedge clk); while (in_stall);
    // Accepted at this edge: update the palette copy or queue the pixel.
    if (act == ACT_PAL_WRITE) begin
      if (int'(idx) < PAL_SIZE) begin
        pal_model[idx] = col;
        if (!pal_written[idx]) pal_filled.push_back(int'(idx));
        pal_written[idx] = 1'b1;
      end
    end else begin
      expected_pixels.push_back(predict_pixel(px));
    end
  endtask

  // Random request: mostly conversions, some palette writes. Palette lookups
  // only hit entries already written.
  task automatic send_random(int write_pct);
    logic [PIXEL_W-1:0] px;
    logic [BYTE_W-1:0]  idx;
    logic [COLOR_W-1:0] col;
    px  = $urandom;
    idx = BYTE_W'($urandom_range(0, 255));
    col = COLOR_W'($urandom);
    if ($urandom_range(0, 99) < write_pct) begin
      send_request(ACT_PAL_WRITE, px, idx, col);
    end else begin
      if (model_cfg.palette_mode) begin
        px[7:0] = BYTE_W'(pal_filled[$urandom_range(0, pal_filled.size() - 1)]);
      end else if ($urandom_range(0, 9) == 0) begin
        // Push alpha to its ends now and then.
        px[8*model_cfg.alpha_pos +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      send_request(ACT_CONVERT, px, idx, col);
    end
  endtask

  // Drop valid, wait for every pending pixel, then let the pipe run dry.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller lowers cfg_valid after the last one.
  task automatic write_register(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      REG_RED_POS:      model_cfg.red_pos      = v;
      REG_GREEN_POS:    model_cfg.green_pos    = v;
      REG_BLUE_POS:     model_cfg.blue_pos     = v;
      REG_ALPHA_POS:    model_cfg.alpha_pos    = v;
      REG_ALPHA_FLAGS:  model_cfg.alpha_flags  = v;
      REG_PALETTE_MODE: model_cfg.palette_mode = v[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(cfg_t c);
    drain_pipeline();
    write_register(REG_RED_POS, c.red_pos);
    write_register(REG_GREEN_POS, c.green_pos);
    write_register(REG_BLUE_POS, c.blue_pos);
    write_register(REG_ALPHA_POS, c.alpha_pos);
    write_register(REG_ALPHA_FLAGS, c.alpha_flags);
    write_register(REG_PALETTE_MODE, {1'b0, c.palette_mode});
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default byte order straight out of reset, opaque alpha, no premultiply.
  task automatic test_reset_defaults();
    send_request(ACT_CONVERT, 32'h0000_0000, 8'h00, 24'h00_0000);
    send_request(ACT_CONVERT, 32'hffff_ffff, 8'hff, 24'hff_ffff);
    send_request(ACT_CONVERT, 32'h4433_2211, 8'h00, 24'h00_0000);
    send_request(ACT_CONVERT, 32'h80ff_007f, 8'h00, 24'h00_0000);
  endtask

  // Channel picking at the extreme byte positions, alpha from source.
  task automatic test_byte_positions();
    apply_config(make_cfg(3, 3, 3, 0, 1, 0));
    send_request(ACT_CONVERT, 32'ha500_0000, 8'h00, 24'h00_0000);
    send_request(ACT_CONVERT, 32'h5a00_00ff, 8'h00, 24'h00_0000);
    apply_config(make_cfg(2, 0, 3, 1, 1, 0));
    send_request(ACT_CONVERT, 32'h4433_2211, 8'h00, 24'h00_0000);
  endtask

  // Premultiply with zero, full and half alpha; premultiply without source
  // alpha leaves colors alone.
  task automatic test_alpha_modes();
    apply_config(make_cfg(0, 1, 2, 3, 3, 0));
    send_request(ACT_CONVERT, 32'h00ff_ffff, 8'h00, 24'h00_0000);
    send_request(ACT_CONVERT, 32'hffff_ffff, 8'h00, 24'h00_0000);
    send_request(ACT_CONVERT, 32'h80ff_4001, 8'h00, 24'h00_0000);
    apply_config(make_cfg(0, 1, 2, 3, 2, 0));
    send_request(ACT_CONVERT, 32'h0012_3456, 8'h00, 24'h00_0000);
  endtask

  // Palette writes give no result; lookups use byte 0 only and ignore the
  // flags and positions. Rewrite an entry and read it on the next request.
  task automatic test_palette_directed();
    apply_config(make_cfg(3, 2, 1, 0, 3, 1));
    send_request(ACT_PAL_WRITE, 32'h0000_0000, 8'h00, 24'hff_ffff);
    send_request(ACT_PAL_WRITE, 32'h0000_0000, 8'hff, 24'h12_3456);
    send_request(ACT_PAL_WRITE, 32'h0000_0000, 8'h80, 24'ha5_a55a);
    send_request(ACT_CONVERT, 32'hffff_ff00, 8'h00, 24'h00_0000);
    send_request(ACT_CONVERT, 32'h0000_00ff, 8'h00, 24'h00_0000);
    send_request(ACT_CONVERT, 32'h1234_5680, 8'h00, 24'h00_0000);
    send_request(ACT_PAL_WRITE, 32'hffff_ffff, 8'h00, 24'h00_0000);
    send_request(ACT_CONVERT, 32'hffff_ff00, 8'h00, 24'h00_0000);
  endtask

  // Random phases over several register settings, extremes first.
  task automatic test_random_phases();
    cfg_t c;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       c = make_cfg(0, 0, 0, 0, 0, 0);
        1:       c = make_cfg(3, 3, 3, 3, 3, 0);
        2:       c = make_cfg(3, 3, 3, 3, 3, 1);
        default: c = make_cfg($urandom_range(0, 3), $urandom_range(0, 3),
                              $urandom_range(0, 3), $urandom_range(0, 3),
                              $urandom_range(0, 3),
                              int'($urandom_range(0, 3) == 0));
      endcase
      apply_config(c);
      // One phase runs with no idling on either side.
      quiet_mode = (ph == 3);
      repeat (160) send_random(8);
    end
    quiet_mode = 1'b0;
  endtask

  // Fill the whole palette, then mix lookups with rewrites.
  task automatic test_palette_fill();
    apply_config(make_cfg($urandom_range(0, 3), $urandom_range(0, 3),
                          $urandom_range(0, 3), $urandom_range(0, 3),
                          $urandom_range(0, 3), 1));
    for (int i = 0; i < PAL_SIZE; i++) begin
      send_request(ACT_PAL_WRITE, $urandom, i[BYTE_W-1:0], COLOR_W'($urandom));
    end
    repeat (250) send_random(15);
  endtask

  // Hold the result side off for a long stretch while requests keep coming,
  // so the pipe fills and in_stall rises.
  task automatic test_result_backpressure();
    apply_config(make_cfg(1, 2, 3, 0, 3, 0));
    quiet_mode = 1'b1;
    hold_left  = 60;
    repeat (40) send_random(0);
    quiet_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: random stalls plus the long hold that a test may request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!quiet_mode && $urandom_range(0, 99) < 25) stall_left = pause_len();
      end
    end
  end

  // Compare each accepted result with the oldest pending pixel.
  always @(posedge clk) begin : result_check
    bgra_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_error($sformatf("unexpected result b=%02h g=%02h r=%02h a=%02h",
                               out_blue, out_green, out_red, out_alpha));
      end else begin
        want = expected_pixels.pop_front();
        if (out_blue !== want.blue)
          report_error($sformatf("blue %02h, expected %02h", out_blue, want.blue));
        if (out_green !== want.green)
          report_error($sformatf("green %02h, expected %02h", out_green, want.green));
        if (out_red !== want.red)
          report_error($sformatf("red %02h, expected %02h", out_red, want.red));
        if (out_alpha !== want.alpha)
          report_error($sformatf("alpha %02h, expected %02h", out_alpha, want.alpha));
      end
    end
  end

  // Watchdog: count cycles in which no channel completes a handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout with %0d results pending", expected_pixels.size());
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_byte_positions();
    test_alpha_modes();
    test_palette_directed();
    test_random_phases();
    test_palette_fill();
    test_result_backpressure();

    drain_pipeline();
    if (expected_pixels.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_pixels.size()));
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
